// ===== hw/rtl/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement core.
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int FRAME_SLOTS = 64;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);

    localparam logic [1:0] KIND_REFERENCE = 2'd0;
    localparam logic [1:0] KIND_OCCUPY    = 2'd1;
    localparam logic [1:0] KIND_EVICT     = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] slot;
        logic       initial_referenced;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [5:0] victim;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FINISH_SIMPLE,
        OP_SWEEP_START,
        OP_SWEEP_PASS,
        OP_SWEEP_TAKE
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       any_occupied;
        logic       pos_occupied;
        logic       pos_referenced;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/clock_page_replacement_core.sv =====
// Top level of the second-chance clock victim selector.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_stall     i_in_item  (kind, slot, initial_referenced)
//   output    out        o_out_valid / i_out_stall   o_out_item (status, victim)
//
// One item is worked on at a time. Reference, occupy and an evict with no
// occupied slot are held in the item register and load their result into the
// output register once it is free; the core then returns to idle for the next item.
// An evict sweeps one slot per cycle from the hand and passes over at most
// 2 * FRAME_SLOTS - 1 slots before it finds its victim, which then waits
// until the output register is free before the next item can be accepted.
// Reset clears all slot bits, the hand and the output valid flag.
// A stalled result holds in the output register while the next item is accepted.
`timescale 1ns / 1ps

module clock_page_replacement_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cpr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cpr_pkg::t_out_item o_out_item
);
    import cpr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    cpr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hw/rtl/cpr_ctrl.sv =====
// Controller state machine for the clock page replacement core.
`timescale 1ns / 1ps

module cpr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cpr_pkg::t_dp_status i_status,
    output cpr_pkg::t_dp_cmd    o_cmd
);
    import cpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.op      = OP_NONE;
        o_in_stall    = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.kind == KIND_EVICT && i_status.any_occupied) begin
                    o_cmd.op = OP_SWEEP_START;
                    n_state  = ST_SWEEP;
                end else if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH_SIMPLE;
                    n_state  = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // An occupied, unreferenced slot is the victim; the result waits
                // here until the output register can take it.
                if (i_status.pos_occupied && !i_status.pos_referenced) begin
                    if (i_status.out_free) begin
                        o_cmd.op = OP_SWEEP_TAKE;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    o_cmd.op = OP_SWEEP_PASS;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cpr_datapath.sv =====
// Slot bit vectors, clock hand, sweep pointer and output register.
`timescale 1ns / 1ps

module cpr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpr_pkg::t_in_item   i_in_item,
    input  cpr_pkg::t_dp_cmd    i_cmd,
    output cpr_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cpr_pkg::t_out_item  o_out_item
);
    import cpr_pkg::*;

    logic [FRAME_SLOTS-1:0] r_occ;
    logic [FRAME_SLOTS-1:0] r_ref;
    logic [SLOT_W-1:0]      r_hand;
    logic [SLOT_W-1:0]      r_pos;
    t_in_item               r_item;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [SLOT_W-1:0] item_idx;
    logic              slot_ok;
    logic [SLOT_W-1:0] pos_next;
    logic              out_load;
    logic              out_free;

    assign item_idx = SLOT_W'(r_item.slot);
    assign slot_ok  = (int'(r_item.slot) < FRAME_SLOTS);
    assign pos_next = (r_pos == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : r_pos + 1'b1;
    assign out_load = (i_cmd.op == OP_FINISH_SIMPLE) || (i_cmd.op == OP_SWEEP_TAKE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.kind           = r_item.kind;
        o_status.any_occupied   = |r_occ;
        o_status.pos_occupied   = r_occ[r_pos];
        o_status.pos_referenced = r_ref[r_pos];
        o_status.out_free       = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.op == OP_SWEEP_START) begin
            r_pos <= r_hand;
        end else if (i_cmd.op == OP_SWEEP_PASS) begin
            r_pos <= pos_next;
        end
        if (i_cmd.op == OP_FINISH_SIMPLE) begin
            r_out.status <= (r_item.kind == KIND_EVICT) ? STATUS_EMPTY : STATUS_OK;
            r_out.victim <= '0;
        end else if (i_cmd.op == OP_SWEEP_TAKE) begin
            r_out.status <= STATUS_OK;
            r_out.victim <= 6'(r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_ref       <= '0;
            r_hand      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_FINISH_SIMPLE: begin
                    if (r_item.kind == KIND_REFERENCE) begin
                        if (slot_ok && r_occ[item_idx]) begin
                            r_ref[item_idx] <= 1'b1;
                        end
                    end else if (r_item.kind == KIND_OCCUPY) begin
                        if (slot_ok) begin
                            r_occ[item_idx] <= 1'b1;
                            r_ref[item_idx] <= r_item.initial_referenced;
                        end
                    end
                end
                OP_SWEEP_PASS: begin
                    // A referenced slot gets its second chance; free slots are skipped.
                    if (r_occ[r_pos]) begin
                        r_ref[r_pos] <= 1'b0;
                    end
                end
                OP_SWEEP_TAKE: begin
                    r_occ[r_pos] <= 1'b0;
                    r_ref[r_pos] <= 1'b0;
                    r_hand       <= pos_next;
                end
                default: begin
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hw/rtl/cpr_checker.sv =====
// Port-level checks for the clock page replacement core, bound to the top level.
`timescale 1ns / 1ps

module cpr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cpr_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cpr_pkg::t_out_item o_out_item
);
    import cpr_pkg::*;

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // The core works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("second item taken while busy");

    // A non-evict item with a free output gives an ok result with victim zero.
    a_simple_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_item.kind != KIND_EVICT) && !o_out_valid
        |-> ##2 (o_out_valid && o_out_item.status == STATUS_OK
                 && o_out_item.victim == 6'd0))
        else $error("simple item result wrong or late");

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (.*);
